@@ rtl/qkt_pkg.sv @@
// ----------------------------------------------------------------------------
// qkt_pkg
// Token kinds, character codes and keyword tables for the query tokenizer.
// ----------------------------------------------------------------------------
package qkt_pkg;

	localparam int NUM_KW = 31;

	// token kinds
	localparam logic [5:0] K_UNION        = 6'd9;
	localparam logic [5:0] K_INTERSECTION = 6'd10;
	localparam logic [5:0] K_DIFFERENCE   = 6'd11;
	localparam logic [5:0] K_SYMDIFF      = 6'd12;
	localparam logic [5:0] K_FILTER       = 6'd14;
	localparam logic [5:0] K_IDENT        = 6'd30;
	localparam logic [5:0] K_NUM          = 6'd31;
	localparam logic [5:0] K_GT           = 6'd32;
	localparam logic [5:0] K_GE           = 6'd33;
	localparam logic [5:0] K_LT           = 6'd34;
	localparam logic [5:0] K_LE           = 6'd35;
	localparam logic [5:0] K_EQ           = 6'd36;
	localparam logic [5:0] K_END          = 6'd37;

	localparam logic signed [4:0] PRIO_NONE    = -5'sd1;
	localparam logic signed [4:0] PRIO_DEFAULT = 5'sd0;
	localparam logic [4:0]        PRIO_CAP     = 5'd15;

	// characters
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_COMMA      = 8'h2C;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_GT         = 8'h3E;
	localparam logic [7:0] CH_LT         = 8'h3C;
	localparam logic [7:0] CH_EQ         = 8'h3D;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_CR         = 8'h0D;

	// result queue
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int MAX_RES = 3;

	typedef struct packed {
		logic [5:0]        kind;
		logic signed [4:0] prio;
		logic [15:0]       start;
		logic [15:0]       len;
	} tok_t;

	// spellings are right-justified: last letter in bits [7:0]
	localparam logic [127:0] KW_SPELL [NUM_KW] = '{
		128'("get"), 128'("elements"), 128'("element"), 128'("of"), 128'("sets"),
		128'("all"), 128'("cache"), 128'("is"), 128'("subset"), 128'("superset"),
		128'("union"), 128'("intersection"), 128'("difference"), 128'("symdiff"),
		128'("where"), 128'("filter"), 128'("create"), 128'("trash"), 128'("from"),
		128'("to"), 128'("add"), 128'("remove"), 128'("delete"), 128'("property"),
		128'("cardinality"), 128'("disjoint"), 128'("equal"), 128'("proper"),
		128'("complement"), 128'("clear"), 128'("update")
	};

	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd3, 4'd8, 4'd7, 4'd2, 4'd4, 4'd3, 4'd5, 4'd2, 4'd6, 4'd8, 4'd5, 4'd12,
		4'd10, 4'd7, 4'd5, 4'd6, 4'd6, 4'd5, 4'd4, 4'd2, 4'd3, 4'd6, 4'd6, 4'd8,
		4'd11, 4'd8, 4'd5, 4'd6, 4'd10, 4'd5, 4'd6
	};

	// "elements" and "element" share one kind
	localparam logic [5:0] KW_KIND [NUM_KW] = '{
		6'd0, 6'd1, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10,
		6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20,
		6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29
	};

	function automatic logic [7:0] kw_char(int j, logic [3:0] k);
		logic [3:0] back;
		logic [6:0] sh;
		back = KW_LEN[j] - 4'd1 - k;
		sh   = {back, 3'b000};
		return KW_SPELL[j][sh +: 8];
	endfunction

	// keywords whose letter at position k equals lc
	function automatic logic [NUM_KW-1:0] kw_match_mask(logic [7:0] lc, logic [15:0] k);
		logic [NUM_KW-1:0] m;
		m = '0;
		for (int j = 0; j < NUM_KW; j++) begin
			if (k < 16'(KW_LEN[j]))
				m[j] = (kw_char(j, k[3:0]) == lc);
		end
		return m;
	endfunction

	// first surviving keyword of matching length, else identifier
	function automatic logic [5:0] kw_word_kind(logic [NUM_KW-1:0] cand, logic [15:0] len);
		logic [5:0] kind;
		kind = K_IDENT;
		for (int j = NUM_KW - 1; j >= 0; j--) begin
			if (cand[j] && (len == 16'(KW_LEN[j])))
				kind = KW_KIND[j];
		end
		return kind;
	endfunction

endpackage

@@ rtl/query_keyword_tokenizer.sv @@
// ----------------------------------------------------------------------------
// query_keyword_tokenizer
// Byte-at-a-time query lexer: keywords, identifiers, numbers, comparison
// operators and dotted words, with an end token after the last byte.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  in      | in_valid/in_stall  | ch, char_present, end_of_query
//  out     | out_valid/out_stall| token_kind, priority_res, token_start,
//          |                    | token_length, last_of_run
//
//  One input beat is lexed per cycle unless in_stall: the lexer state plus the
//  byte go through one level of logic into a 4-entry token queue in the same cycle.
//  Each beat yields 0 to 3 tokens; the queue drains one token per cycle unless
//  out_stall. in_stall rises while the queue holds more than one token, so a beat
//  with at most one token sustains 1 beat/cycle unless out_stall, and a 3-token
//  beat costs the queue drain time. arst_n clears lexer state and empties the queue.
//
module query_keyword_tokenizer import qkt_pkg::*; #(
	parameter int MAX_QUERY_BYTES = 65536,
	parameter int MAX_DOT_COUNT   = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        ch,
	input  logic              char_present,
	input  logic              end_of_query,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [5:0]        token_kind,
	output logic signed [4:0] priority_res,
	output logic [15:0]       token_start,
	output logic [15:0]       token_length,
	output logic              last_of_run
);

	localparam int POS_W = $clog2(MAX_QUERY_BYTES + 1);
	localparam int DOT_W = $clog2(MAX_DOT_COUNT + 1);

	typedef enum logic [2:0] {
		MODE_IDLE, MODE_WORD, MODE_NUM, MODE_GT, MODE_LT,
		MODE_LDOTS, MODE_DWORD, MODE_TDOTS
	} mode_t;

	typedef struct packed {
		tok_t tok;
		logic last;
	} q_ent_t;

	// lexer state
	mode_t             mode_q;
	logic [NUM_KW-1:0] cand_q;
	logic [15:0]       wlen_q;
	logic [POS_W-1:0]  pos_q;
	logic [15:0]       start_q;
	logic [DOT_W-1:0]  lead_q;
	logic [DOT_W-1:0]  trail_q;

	// token queue
	q_ent_t          q_mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   cnt_q;

	function automatic logic [15:0] sat16(logic [POS_W-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic tok_t word_tok(logic [NUM_KW-1:0] cand, logic [15:0] len,
			logic [15:0] start, logic dotted, logic [DOT_W-1:0] ld, logic [DOT_W-1:0] tr);
		tok_t t;
		t.kind  = kw_word_kind(cand, len);
		t.start = start;
		t.len   = len;
		// set operators and filter default to 0
		if (t.kind == K_UNION || t.kind == K_INTERSECTION || t.kind == K_DIFFERENCE ||
				t.kind == K_SYMDIFF || t.kind == K_FILTER)
			t.prio = PRIO_DEFAULT;
		else
			t.prio = PRIO_NONE;
		// balanced dots set the priority, capped
		if (dotted && (ld == tr)) begin
			if (32'(ld) > 32'(PRIO_CAP))
				t.prio = $signed(PRIO_CAP);
			else
				t.prio = $signed(5'(ld));
		end
		return t;
	endfunction

	function automatic tok_t plain_tok(logic [5:0] kind, logic [15:0] start,
			logic [15:0] len);
		tok_t t;
		t.kind  = kind;
		t.prio  = PRIO_NONE;
		t.start = start;
		t.len   = len;
		return t;
	endfunction

	// handshake
	logic accept;
	logic pop;
	assign in_stall  = (cnt_q > (Q_AW + 1)'(Q_DEPTH - MAX_RES));
	assign accept    = in_valid && !in_stall;
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;

	// byte classes
	logic       present;
	logic       is_alpha, is_digit, is_word, is_space, is_dot;
	logic [7:0] lc;
	logic [15:0] pos16;

	assign present  = char_present && (pos_q < POS_W'(MAX_QUERY_BYTES));
	assign is_alpha = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
	assign is_digit = (ch >= "0") && (ch <= "9");
	assign is_word  = is_alpha || is_digit || (ch == CH_UNDERSCORE);
	assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
	assign is_dot   = (ch == CH_DOT);
	assign lc       = ((ch >= "A") && (ch <= "Z")) ? ch + 8'd32 : ch;
	assign pos16    = sat16(pos_q);

	logic [NUM_KW-1:0] mask_begin, mask_add;
	logic [15:0]       wlen_inc;
	logic [DOT_W-1:0]  lead_inc, trail_inc;

	assign mask_begin = kw_match_mask(lc, 16'd0);
	assign mask_add   = kw_match_mask(lc, wlen_q);
	assign wlen_inc   = (wlen_q == 16'hFFFF) ? wlen_q : wlen_q + 16'd1;
	assign lead_inc   = (lead_q < DOT_W'(MAX_DOT_COUNT)) ? lead_q + DOT_W'(1) : lead_q;
	assign trail_inc  = (trail_q < DOT_W'(MAX_DOT_COUNT)) ? trail_q + DOT_W'(1) : trail_q;

	// lex step: state after the byte, the token it closes, and a lone '='
	mode_t             lx_mode;
	logic [NUM_KW-1:0] lx_cand;
	logic [15:0]       lx_wlen, lx_start;
	logic [POS_W-1:0]  lx_pos;
	logic [DOT_W-1:0]  lx_lead, lx_trail;
	logic              e1_v, e2_v, fresh;
	tok_t              e1, e2;

	always_comb begin
		lx_mode  = mode_q;
		lx_cand  = cand_q;
		lx_wlen  = wlen_q;
		lx_start = start_q;
		lx_pos   = pos_q;
		lx_lead  = lead_q;
		lx_trail = trail_q;
		e1_v     = 1'b0;
		e1       = word_tok(cand_q, wlen_q, start_q, 1'b0, lead_q, trail_q);
		e2_v     = 1'b0;
		e2       = plain_tok(K_EQ, pos16, 16'd1);
		fresh    = 1'b0;
		if (present) begin
			lx_pos = pos_q + POS_W'(1);
			case (mode_q)
				MODE_WORD: begin
					if (is_word) begin
						lx_cand = cand_q & mask_add;
						lx_wlen = wlen_inc;
					end else begin
						e1_v  = 1'b1;
						fresh = 1'b1;
					end
				end
				MODE_DWORD: begin
					if (is_word) begin
						lx_cand = cand_q & mask_add;
						lx_wlen = wlen_inc;
					end else if (is_dot) begin
						lx_trail = DOT_W'(1);
						lx_mode  = MODE_TDOTS;
					end else begin
						e1_v  = 1'b1;
						e1    = word_tok(cand_q, wlen_q, start_q, 1'b1, lead_q, trail_q);
						fresh = 1'b1;
					end
				end
				MODE_TDOTS: begin
					if (is_dot) begin
						lx_trail = trail_inc;
					end else begin
						e1_v  = 1'b1;
						e1    = word_tok(cand_q, wlen_q, start_q, 1'b1, lead_q, trail_q);
						fresh = 1'b1;
					end
				end
				MODE_NUM: begin
					if (is_digit || is_dot) begin
						lx_wlen = wlen_inc;
					end else begin
						e1_v  = 1'b1;
						e1    = plain_tok(K_NUM, start_q, wlen_q);
						fresh = 1'b1;
					end
				end
				MODE_GT, MODE_LT: begin
					e1_v = 1'b1;
					if (ch == CH_EQ) begin
						e1      = plain_tok((mode_q == MODE_GT) ? K_GE : K_LE, start_q, 16'd2);
						lx_mode = MODE_IDLE;
					end else begin
						e1    = plain_tok((mode_q == MODE_GT) ? K_GT : K_LT, start_q, 16'd1);
						fresh = 1'b1;
					end
				end
				MODE_LDOTS: begin
					if (is_dot) begin
						lx_lead = lead_inc;
					end else if (is_alpha) begin
						lx_start = pos16;
						lx_wlen  = 16'd1;
						lx_cand  = mask_begin;
						lx_mode  = MODE_DWORD;
					end else begin
						fresh = 1'b1;
					end
				end
				default: fresh = 1'b1;
			endcase
			// byte starts a token of its own; spaces, commas, strays fall out
			if (fresh) begin
				lx_mode = MODE_IDLE;
				if (is_dot) begin
					lx_lead  = DOT_W'(1);
					lx_trail = '0;
					lx_mode  = MODE_LDOTS;
				end else if (is_alpha) begin
					lx_start = pos16;
					lx_wlen  = 16'd1;
					lx_cand  = mask_begin;
					lx_mode  = MODE_WORD;
				end else if (is_digit) begin
					lx_start = pos16;
					lx_wlen  = 16'd1;
					lx_mode  = MODE_NUM;
				end else if (ch == CH_GT) begin
					lx_start = pos16;
					lx_mode  = MODE_GT;
				end else if (ch == CH_LT) begin
					lx_start = pos16;
					lx_mode  = MODE_LT;
				end else if (ch == CH_EQ) begin
					e2_v = 1'b1;
				end
			end
		end
	end

	// end of query: flush a pending token, then the end token
	logic f1_v;
	tok_t f1, f2;

	always_comb begin
		f1_v = 1'b0;
		f1   = word_tok(lx_cand, lx_wlen, lx_start, 1'b0, lx_lead, lx_trail);
		f2   = plain_tok(K_END, sat16(lx_pos), 16'd0);
		if (end_of_query) begin
			case (lx_mode)
				MODE_WORD: f1_v = 1'b1;
				MODE_DWORD, MODE_TDOTS: begin
					f1_v = 1'b1;
					f1   = word_tok(lx_cand, lx_wlen, lx_start, 1'b1, lx_lead, lx_trail);
				end
				MODE_NUM: begin
					f1_v = 1'b1;
					f1   = plain_tok(K_NUM, lx_start, lx_wlen);
				end
				MODE_GT: begin
					f1_v = 1'b1;
					f1   = plain_tok(K_GT, lx_start, 16'd1);
				end
				MODE_LT: begin
					f1_v = 1'b1;
					f1   = plain_tok(K_LT, lx_start, 16'd1);
				end
				default: f1_v = 1'b0;
			endcase
		end
	end

	// pack this beat's tokens in order
	tok_t       res [MAX_RES];
	logic [1:0] res_n;
	tok_t       slot_tok [4];
	logic [3:0] slot_v;

	always_comb begin
		slot_tok[0] = e1;
		slot_tok[1] = e2;
		slot_tok[2] = f1;
		slot_tok[3] = f2;
		slot_v      = {end_of_query, f1_v, e2_v, e1_v};
		res_n       = 2'd0;
		for (int i = 0; i < MAX_RES; i++)
			res[i] = '0;
		for (int i = 0; i < 4; i++) begin
			if (slot_v[i] && (res_n < 2'(MAX_RES))) begin
				res[res_n] = slot_tok[i];
				res_n      = res_n + 2'd1;
			end
		end
	end

	logic [Q_AW:0] push_n;
	assign push_n = accept ? (Q_AW + 1)'(res_n) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			cand_q  <= '1;
			wlen_q  <= '0;
			pos_q   <= '0;
			start_q <= '0;
			lead_q  <= '0;
			trail_q <= '0;
			wr_q    <= '0;
			rd_q    <= '0;
			cnt_q   <= '0;
		end else begin
			if (accept) begin
				if (end_of_query) begin
					// end token returns the lexer state to reset
					mode_q  <= MODE_IDLE;
					cand_q  <= '1;
					wlen_q  <= '0;
					pos_q   <= '0;
					start_q <= '0;
					lead_q  <= '0;
					trail_q <= '0;
				end else begin
					mode_q  <= lx_mode;
					cand_q  <= lx_cand;
					wlen_q  <= lx_wlen;
					pos_q   <= lx_pos;
					start_q <= lx_start;
					lead_q  <= lx_lead;
					trail_q <= lx_trail;
				end
				for (int i = 0; i < MAX_RES; i++) begin
					if (2'(i) < res_n) begin
						q_mem[wr_q + Q_AW'(i)].tok  <= res[i];
						q_mem[wr_q + Q_AW'(i)].last <= (2'(i) == res_n - 2'd1);
					end
				end
				wr_q <= wr_q + Q_AW'(res_n);
			end
			if (pop)
				rd_q <= rd_q + Q_AW'(1);
			cnt_q <= cnt_q + push_n - (Q_AW + 1)'(pop);
		end
	end

	assign token_kind   = q_mem[rd_q].tok.kind;
	assign priority_res = q_mem[rd_q].tok.prio;
	assign token_start  = q_mem[rd_q].tok.start;
	assign token_length = q_mem[rd_q].tok.len;
	assign last_of_run  = q_mem[rd_q].last;

endmodule

@@ rtl/qkt_checker.sv @@
// ----------------------------------------------------------------------------
// qkt_checker
// Port-level checks on the query tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module qkt_checker import qkt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic [7:0]        ch,
	input logic              char_present,
	input logic              end_of_query,
	input logic              out_valid,
	input logic              out_stall,
	input logic [5:0]        token_kind,
	input logic signed [4:0] priority_res,
	input logic [15:0]       token_start,
	input logic [15:0]       token_length,
	input logic              last_of_run
);

	// end token always closes its beat's run
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && token_kind == K_END) |-> (last_of_run && token_length == 16'd0))
		else $error("end token not last of run or nonzero length");

	// two-char operators carry length 2
	a_ge_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (token_kind == K_GE || token_kind == K_LE)) |-> (token_length == 16'd2))
		else $error(">= or <= with wrong length");

	// only keywords and identifiers take a priority other than none
	a_prio_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (token_kind == K_NUM || token_kind == K_GT || token_kind == K_GE ||
			token_kind == K_LT || token_kind == K_LE || token_kind == K_EQ ||
			token_kind == K_END)) |-> (priority_res == PRIO_NONE))
		else $error("priority on a non-word token");

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(token_kind) &&
			$stable(token_start) && $stable(last_of_run)))
		else $error("stalled output beat changed");

endmodule

bind query_keyword_tokenizer qkt_checker u_qkt_checker (.*);

@@ test/qkt_token_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qkt_token_checker
// Watches both channels of the query tokenizer. Every accepted input beat is
// run through a lexer model kept here, and every accepted output beat is
// compared field by field with the oldest token that the model still owes.
// ----------------------------------------------------------------------------
module qkt_token_checker import qkt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [7:0]        ch,
	input  logic              char_present,
	input  logic              end_of_query,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [5:0]        token_kind,
	input  logic signed [4:0] priority_res,
	input  logic [15:0]       token_start,
	input  logic [15:0]       token_length,
	input  logic              last_of_run,
	output int                fail_count,
	output int                tokens_pending
);

	localparam int QUERY_BYTES_MAX = 65536;
	localparam int DOT_SAT         = 15;
	localparam int LEN_SAT         = 65535;
	localparam int WORD_KEEP       = 16;

	localparam logic [7:0] CH_LA = "a";
	localparam logic [7:0] CH_LZ = "z";
	localparam logic [7:0] CH_UA = "A";
	localparam logic [7:0] CH_UZ = "Z";
	localparam logic [7:0] CH_D0 = "0";
	localparam logic [7:0] CH_D9 = "9";

	typedef enum logic [3:0] {
		LX_IDLE, LX_WORD, LX_NUM, LX_GT, LX_LT, LX_LDOTS, LX_DWORD, LX_TDOTS
	} lexer_mode_e;

	typedef struct {
		logic [5:0]        kind;
		logic signed [4:0] prio;
		logic [15:0]       start;
		logic [15:0]       len;
		logic              last;
	} token_t;

	// keyword spellings in table order; index 2 ("element") shares kind 1
	string kw_words [NUM_KW] = '{
		"get", "elements", "element", "of", "sets", "all", "cache", "is",
		"subset", "superset", "union", "intersection", "difference", "symdiff",
		"where", "filter", "create", "trash", "from", "to", "add", "remove",
		"delete", "property", "cardinality", "disjoint", "equal", "proper",
		"complement", "clear", "update"
	};

	token_t      tokens_due [$];
	token_t      step_tokens [$];
	int          mismatches;

	lexer_mode_e lex_mode;
	logic [7:0]  word_buf [WORD_KEEP];
	int          word_len;
	int          byte_pos;
	int          tok_start;
	int          lead_dots;
	int          trail_dots;

	function automatic bit is_letter(logic [7:0] c);
		return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_D0 && c <= CH_D9;
	endfunction

	function automatic bit is_word_char(logic [7:0] c);
		return is_letter(c) || is_digit(c) || c == CH_UNDERSCORE;
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [15:0] sat16(int v);
		return (v > LEN_SAT) ? 16'hFFFF : 16'(v);
	endfunction

	// exact match of the lowercased word against the table, first entry wins
	function automatic logic [5:0] word_kind();
		bit hit;
		for (int j = 0; j < NUM_KW; j++) begin
			if (word_len == kw_words[j].len()) begin
				hit = 1'b1;
				for (int k = 0; k < word_len; k++)
					if (word_buf[k] != kw_words[j][k])
						hit = 1'b0;
				if (hit)
					return 6'((j < 2) ? j : j - 1);
			end
		end
		return K_IDENT;
	endfunction

	task automatic reset_lexer();
		lex_mode   = LX_IDLE;
		word_len   = 0;
		byte_pos   = 0;
		tok_start  = 0;
		lead_dots  = 0;
		trail_dots = 0;
	endtask

	task automatic add_token(logic [5:0] kind, logic signed [4:0] prio, int start, int len);
		token_t t;
		if (step_tokens.size() >= MAX_RES)
			return;
		t.kind  = kind;
		t.prio  = prio;
		t.start = sat16(start);
		t.len   = sat16(len);
		t.last  = 1'b0;
		step_tokens = {step_tokens, t};
	endtask

	task automatic take_word_char(logic [7:0] c);
		logic [7:0] lc;
		lc = (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
		if (word_len < WORD_KEEP)
			word_buf[word_len] = lc;
		if (word_len < LEN_SAT)
			word_len++;
	endtask

	task automatic start_word(logic [7:0] c, int p);
		tok_start = p;
		word_len  = 0;
		take_word_char(c);
	endtask

	task automatic close_word(bit dotted);
		logic [5:0]        kind;
		logic signed [4:0] prio;
		kind = word_kind();
		prio = PRIO_NONE;
		if (kind inside {K_UNION, K_INTERSECTION, K_DIFFERENCE, K_SYMDIFF, K_FILTER})
			prio = PRIO_DEFAULT;
		if (dotted && lead_dots == trail_dots)
			prio = (lead_dots >= PRIO_CAP) ? signed'(PRIO_CAP) : signed'(5'(lead_dots));
		add_token(kind, prio, tok_start, word_len);
	endtask

	task automatic lex_query_byte(logic [7:0] c, int p);
		case (lex_mode)
			LX_WORD: begin
				if (is_word_char(c)) begin
					take_word_char(c);
					return;
				end
				close_word(1'b0);
			end
			LX_DWORD: begin
				if (is_word_char(c)) begin
					take_word_char(c);
					return;
				end
				if (c == CH_DOT) begin
					trail_dots = 1;
					lex_mode   = LX_TDOTS;
					return;
				end
				close_word(1'b1);
			end
			LX_TDOTS: begin
				if (c == CH_DOT) begin
					if (trail_dots < DOT_SAT)
						trail_dots++;
					return;
				end
				close_word(1'b1);
			end
			LX_NUM: begin
				if (is_digit(c) || c == CH_DOT) begin
					if (word_len < LEN_SAT)
						word_len++;
					return;
				end
				add_token(K_NUM, PRIO_NONE, tok_start, word_len);
			end
			LX_GT, LX_LT: begin
				if (c == CH_EQ) begin
					add_token((lex_mode == LX_GT) ? K_GE : K_LE, PRIO_NONE, tok_start, 2);
					lex_mode = LX_IDLE;
					return;
				end
				add_token((lex_mode == LX_GT) ? K_GT : K_LT, PRIO_NONE, tok_start, 1);
			end
			LX_LDOTS: begin
				if (c == CH_DOT) begin
					if (lead_dots < DOT_SAT)
						lead_dots++;
					return;
				end
				if (is_letter(c)) begin
					start_word(c, p);
					lex_mode = LX_DWORD;
					return;
				end
				// dots with no word behind them vanish; this byte starts afresh
			end
			default: ;
		endcase
		lex_mode = LX_IDLE;
		if (is_blank(c) || c == CH_COMMA)
			return;
		if (c == CH_DOT) begin
			lead_dots  = 1;
			trail_dots = 0;
			lex_mode   = LX_LDOTS;
		end else if (is_letter(c)) begin
			start_word(c, p);
			lex_mode = LX_WORD;
		end else if (is_digit(c)) begin
			tok_start = p;
			word_len  = 1;
			lex_mode  = LX_NUM;
		end else if (c == CH_GT || c == CH_LT) begin
			tok_start = p;
			lex_mode  = (c == CH_GT) ? LX_GT : LX_LT;
		end else if (c == CH_EQ) begin
			add_token(K_EQ, PRIO_NONE, p, 1);
		end
	endtask

	task automatic end_query();
		case (lex_mode)
			LX_WORD:           close_word(1'b0);
			LX_DWORD, LX_TDOTS: close_word(1'b1);
			LX_NUM:            add_token(K_NUM, PRIO_NONE, tok_start, word_len);
			LX_GT:             add_token(K_GT, PRIO_NONE, tok_start, 1);
			LX_LT:             add_token(K_LT, PRIO_NONE, tok_start, 1);
			default: ;
		endcase
		add_token(K_END, PRIO_NONE, byte_pos, 0);
		reset_lexer();
	endtask

	task automatic predict_beat(logic [7:0] c, logic present, logic eoq);
		step_tokens.delete();
		// bytes past the size limit are not lexed and do not advance the offset
		if (present && byte_pos < QUERY_BYTES_MAX) begin
			lex_query_byte(c, byte_pos);
			byte_pos++;
		end
		if (eoq)
			end_query();
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i])
			tokens_due = {tokens_due, step_tokens[i]};
	endtask

	task automatic check_token();
		token_t want;
		if (tokens_due.size() == 0) begin
			$error("unexpected token: token_kind %0d token_start %0d", token_kind, token_start);
			mismatches++;
			return;
		end
		want = tokens_due.pop_front();
		if (token_kind !== want.kind) begin
			$error("token_kind: expected %0d, actual %0d", want.kind, token_kind);
			mismatches++;
		end
		if (priority_res !== want.prio) begin
			$error("priority_res: expected %0d, actual %0d", want.prio, priority_res);
			mismatches++;
		end
		if (token_start !== want.start) begin
			$error("token_start: expected %0d, actual %0d", want.start, token_start);
			mismatches++;
		end
		if (token_length !== want.len) begin
			$error("token_length: expected %0d, actual %0d", want.len, token_length);
			mismatches++;
		end
		if (last_of_run !== want.last) begin
			$error("last_of_run: expected %0d, actual %0d", want.last, last_of_run);
			mismatches++;
		end
	endtask

	initial begin
		mismatches = 0;
		reset_lexer();
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_lexer();
			tokens_due.delete();
		end else begin
			// input first, so a token can never be looked for before its beat
			if (in_valid === 1'b1 && in_stall === 1'b0)
				predict_beat(ch, char_present, end_of_query);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				check_token();
		end
		fail_count     <= mismatches;
		tokens_pending <= tokens_due.size();
	end

endmodule

@@ test/tb_query_keyword_tokenizer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_query_keyword_tokenizer
// Stimulus and verdict for the query tokenizer. A short directed set of
// queries covers the corner cases, then random queries run under four
// idle/stall mixes. Token checking lives in qkt_token_checker.
// ----------------------------------------------------------------------------
module tb_query_keyword_tokenizer import qkt_pkg::*;;

	localparam int PHASE_ITEMS  = 70;    // random beats per idle/stall mix
	localparam int HOLDOFF_LONG = 60;    // receiver hold-off, in cycles
	localparam int TAIL_CYCLES  = 20;    // settle time after the last token

	localparam logic [7:0] CH_LA = "a";
	localparam logic [7:0] CH_UA = "A";
	localparam logic [7:0] CH_D0 = "0";

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [7:0]        ch;
	logic              char_present;
	logic              end_of_query;
	logic              out_valid;
	logic              out_stall;
	logic [5:0]        token_kind;
	logic signed [4:0] priority_res;
	logic [15:0]       token_start;
	logic [15:0]       token_length;
	logic              last_of_run;

	int fail_count;
	int tokens_pending;

	// knobs shared by the sender and the receiver
	int send_idle_pct;
	int stall_pct;
	int holdoff_req;
	int beats_sent;     // beats that carry a byte or close a query

	logic [7:0] query_bytes [$];

	string kw_list [NUM_KW] = '{
		"get", "elements", "element", "of", "sets", "all", "cache", "is",
		"subset", "superset", "union", "intersection", "difference", "symdiff",
		"where", "filter", "create", "trash", "from", "to", "add", "remove",
		"delete", "property", "cardinality", "disjoint", "equal", "proper",
		"complement", "clear", "update"
	};

	query_keyword_tokenizer uut (.*);
	qkt_token_checker       chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop; far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: random stall each cycle, or a long hold-off when asked for.
	// The hold-off is counted down here so the sender keeps running meanwhile.
	initial begin
		int holdoff_left;
		holdoff_left = 0;
		out_stall    = 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_req > 0) begin
				holdoff_left = holdoff_req;
				holdoff_req  = 0;
			end
			if (holdoff_left > 0) begin
				out_stall <= 1'b1;
				holdoff_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// One input beat: optional idle cycles first, then hold the payload until
	// a clock edge sees valid high and stall low. Returns right after that edge.
	task automatic send_beat(logic [7:0] c, logic present, logic eoq);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		ch           <= c;
		char_present <= present;
		end_of_query <= eoq;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (present || eoq)
			beats_sent++;
	endtask

	task automatic send_text(string s, logic eoq);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b1, eoq && i == s.len() - 1);
	endtask

	// Drop valid and wait for the block to hand back everything it owes.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tokens_pending != 0)
			@(posedge clk);
	endtask

	task automatic put_byte(logic [7:0] b);
		query_bytes = {query_bytes, b};
	endtask

	function automatic logic [7:0] rand_letter();
		return ($urandom_range(1) ? CH_UA : CH_LA) + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] rand_word_char();
		case ($urandom_range(3))
			0, 1:    return rand_letter();
			2:       return CH_D0 + 8'($urandom_range(9));
			default: return CH_UNDERSCORE;
		endcase
	endfunction

	// mostly short runs of dots, now and then past the saturation point
	function automatic int rand_dots();
		return ($urandom_range(5) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 3);
	endfunction

	function automatic logic [7:0] rand_separator();
		case ($urandom_range(3))
			0:       return CH_SPACE;
			1:       return CH_COMMA;
			default: return 8'($urandom_range(CH_TAB, CH_CR));
		endcase
	endfunction

	// keyword with each letter in random case
	task automatic add_keyword();
		string      w;
		logic [7:0] c;
		w = kw_list[$urandom_range(NUM_KW - 1)];
		for (int i = 0; i < w.len(); i++) begin
			c = w[i];
			if ($urandom_range(1))
				c = c - 8'd32;
			put_byte(c);
		end
	endtask

	task automatic add_ident();
		put_byte(rand_letter());
		repeat ($urandom_range(6))
			put_byte(rand_word_char());
	endtask

	task automatic add_operator();
		case ($urandom_range(4))
			0: put_byte(CH_GT);
			1: put_byte(CH_LT);
			2: begin
				put_byte(CH_GT);
				put_byte(CH_EQ);
			end
			3: begin
				put_byte(CH_LT);
				put_byte(CH_EQ);
			end
			default: put_byte(CH_EQ);
		endcase
	endtask

	// Random query built from well-formed pieces, with stray bytes, lone dots
	// and dropped separators mixed in so the lookahead paths get exercised.
	task automatic build_query();
		int lead;
		int trail;
		query_bytes.delete();
		if ($urandom_range(19) == 0)
			return;    // empty query
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(15))
				0, 1, 2, 3, 4, 15: add_keyword();
				5, 6: add_ident();
				7: begin
					put_byte(CH_D0 + 8'($urandom_range(9)));
					repeat ($urandom_range(5))
						put_byte($urandom_range(3) == 0 ? CH_DOT :
							CH_D0 + 8'($urandom_range(9)));
				end
				8, 9: add_operator();
				10, 11: begin
					// dotted word: equal counts half the time
					lead  = rand_dots();
					trail = $urandom_range(1) ? lead :
						($urandom_range(1) ? rand_dots() : 0);
					repeat (lead)
						put_byte(CH_DOT);
					if ($urandom_range(1))
						add_keyword();
					else
						add_ident();
					repeat (trail)
						put_byte(CH_DOT);
				end
				12: repeat ($urandom_range(1, 4))
					put_byte(CH_DOT);
				13: put_byte(8'($urandom_range(255)));
				default: repeat ($urandom_range(1, 3))
					put_byte(rand_separator());
			endcase
			if ($urandom_range(3) != 0)
				put_byte(rand_separator());
		end
	endtask

	// Sends the query; sometimes it is closed by a beat without a byte, and
	// now and then an empty beat (no byte, no end) slips in between.
	task automatic send_query();
		bit closed_empty;
		closed_empty = (query_bytes.size() == 0) || ($urandom_range(7) == 0);
		foreach (query_bytes[i]) begin
			if ($urandom_range(15) == 0)
				send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
			send_beat(query_bytes[i], 1'b1, !closed_empty && i == query_bytes.size() - 1);
		end
		if (closed_empty)
			send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	initial begin
		int mark;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		ch            = '0;
		char_present  = 1'b0;
		end_of_query  = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		holdoff_req   = 0;
		beats_sent    = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: no idling on either side ---
		// empty query: only the end token, at offset 0
		send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
		// identifier, >=, number with a dot, and a '<' still pending at the end
		send_text("a>=1.2<", 1'b1);
		// dotted keyword with matching dots, then a plain word right after
		send_text("..Filter..x", 1'b1);
		// high byte dropped, comma skipped, a lone dot swallowed before '='
		send_beat(8'hFF, 1'b1, 1'b0);
		send_text(",.=", 1'b1);
		// query closed by a beat that carries no byte
		send_text("to", 1'b0);
		send_beat(8'($urandom_range(255)), 1'b0, 1'b1);

		// Receiver holds off while one '=' token per two beats keeps coming:
		// the token queue fills and the block has to stall its input.
		holdoff_req = HOLDOFF_LONG;
		send_text("=,=,=,=,=,=,=,=,=,=", 1'b1);
		drain();

		// --- random queries under four idle/stall mixes ---
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 46; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 46; end
				default: begin send_idle_pct = 17; stall_pct = 17; end
			endcase
			mark = beats_sent;
			while (beats_sent - mark < PHASE_ITEMS) begin
				build_query();
				send_query();
			end
			// sender pauses here until every owed token is back
			drain();
		end

		// any stray token in this window is flagged by the checker
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
